// ----- rtl/eight_bit_alu_with_flags_macros.svh -----
// Assertion macros for the eight-bit ALU.
// Used by the top level only; expects clk and arst_n in scope.
`ifndef EIGHT_BIT_ALU_WITH_FLAGS_MACROS_SVH
`define EIGHT_BIT_ALU_WITH_FLAGS_MACROS_SVH

// Same-cycle implication, checked out of reset
`define EALU_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked out of reset
`define EALU_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/ealu_pkg.sv -----
// Shared types and operation codes for the eight-bit ALU.
// No dependencies; imported by ealu_core and eight_bit_alu_with_flags.
`default_nettype none

package ealu_pkg;

	// Operation codes carried in the cmd field
	typedef enum logic [4:0] {
		CMD_ADD  = 5'd0,
		CMD_SUB  = 5'd1,
		CMD_AND  = 5'd2,
		CMD_OR   = 5'd3,
		CMD_XOR  = 5'd4,
		CMD_CP   = 5'd5,
		CMD_INC  = 5'd6,
		CMD_DEC  = 5'd7,
		CMD_RLC  = 5'd8,
		CMD_RRC  = 5'd9,
		CMD_RL   = 5'd10,
		CMD_RR   = 5'd11,
		CMD_SLA  = 5'd12,
		CMD_SRA  = 5'd13,
		CMD_SRL  = 5'd14,
		CMD_SWAP = 5'd15,
		CMD_BIT  = 5'd16
	} alu_cmd_t;

	localparam logic [3:0] NIBBLE_ALL_ONES = 4'hf;

	// Stored condition flags
	typedef struct packed {
		logic z;
		logic n;
		logic h;
		logic c;
	} alu_flags_t;

	// One operation request
	typedef struct packed {
		logic [4:0] cmd;
		logic [7:0] operand_a;
		logic [7:0] operand_b;
		logic       carry_in;
		logic [2:0] bit_index;
	} alu_req_t;

	// One operation result
	typedef struct packed {
		logic [7:0] result_byte;
		logic       result_written;
		logic       zero_out;
		logic       subtract_out;
		logic       half_carry_out;
		logic       carry_out;
	} alu_res_t;

endpackage

`default_nettype wire

// ----- rtl/ealu_core.sv -----
// Combinational datapath of the eight-bit ALU: adder, logic ops, shifter, bit test.
// Depends on ealu_pkg for the request, result and flag types.
`default_nettype none

module ealu_core
	import ealu_pkg::*;
(
	input  wire alu_req_t   req,
	input  wire alu_flags_t flags,
	output alu_res_t        res
);

	logic [8:0] sum9;
	logic [4:0] sum_lo;
	logic [8:0] diff9;
	logic [4:0] diff_lo;
	logic       sub_ci;
	logic [7:0] a;
	logic [7:0] b;
	logic [7:0] r;
	logic       wr;
	alu_flags_t nf;

	assign a = req.operand_a;
	assign b = req.operand_b;

	// Compare drops the extra borrow
	assign sub_ci = (req.cmd == CMD_CP) ? 1'b0 : req.carry_in;

	// Add and subtract with nibble carry for half-carry
	assign sum9    = {1'b0, a} + {1'b0, b} + {8'd0, req.carry_in};
	assign sum_lo  = {1'b0, a[3:0]} + {1'b0, b[3:0]} + {4'd0, req.carry_in};
	assign diff9   = {1'b0, a} - {1'b0, b} - {8'd0, sub_ci};
	assign diff_lo = {1'b0, a[3:0]} - {1'b0, b[3:0]} - {4'd0, sub_ci};

	// Decode the operation into byte and new flags
	always_comb begin
		r  = 8'd0;
		wr = 1'b1;
		nf = flags;
		unique case (alu_cmd_t'(req.cmd))
			CMD_ADD: begin
				r  = sum9[7:0];
				nf = '{z: (r == 8'd0), n: 1'b0, h: sum_lo[4], c: sum9[8]};
			end
			CMD_SUB, CMD_CP: begin
				r  = diff9[7:0];
				nf = '{z: (r == 8'd0), n: 1'b1, h: diff_lo[4], c: diff9[8]};
				if (req.cmd == CMD_CP) begin
					r  = 8'd0;
					wr = 1'b0;
				end
			end
			CMD_AND: begin
				r  = a & b;
				nf = '{z: (r == 8'd0), n: 1'b0, h: 1'b1, c: 1'b0};
			end
			CMD_OR: begin
				r  = a | b;
				nf = '{z: (r == 8'd0), n: 1'b0, h: 1'b0, c: 1'b0};
			end
			CMD_XOR: begin
				r  = a ^ b;
				nf = '{z: (r == 8'd0), n: 1'b0, h: 1'b0, c: 1'b0};
			end
			CMD_INC: begin
				r  = a + 8'd1;
				nf = '{z: (r == 8'd0), n: 1'b0, h: (r[3:0] == 4'd0), c: flags.c};
			end
			CMD_DEC: begin
				r  = a - 8'd1;
				nf = '{z: (r == 8'd0), n: 1'b1, h: (r[3:0] == NIBBLE_ALL_ONES), c: flags.c};
			end
			CMD_RLC: begin
				r  = {a[6:0], a[7]};
				nf = '{z: (r == 8'd0), n: 1'b0, h: 1'b0, c: a[7]};
			end
			CMD_RRC: begin
				r  = {a[0], a[7:1]};
				nf = '{z: (r == 8'd0), n: 1'b0, h: 1'b0, c: a[0]};
			end
			CMD_RL: begin
				r  = {a[6:0], flags.c};
				nf = '{z: (r == 8'd0), n: 1'b0, h: 1'b0, c: a[7]};
			end
			CMD_RR: begin
				r  = {flags.c, a[7:1]};
				nf = '{z: (r == 8'd0), n: 1'b0, h: 1'b0, c: a[0]};
			end
			CMD_SLA: begin
				r  = {a[6:0], 1'b0};
				nf = '{z: (r == 8'd0), n: 1'b0, h: 1'b0, c: a[7]};
			end
			CMD_SRA: begin
				r  = {a[7], a[7:1]};
				nf = '{z: (r == 8'd0), n: 1'b0, h: 1'b0, c: a[0]};
			end
			CMD_SRL: begin
				r  = {1'b0, a[7:1]};
				nf = '{z: (r == 8'd0), n: 1'b0, h: 1'b0, c: a[0]};
			end
			CMD_SWAP: begin
				r  = {a[3:0], a[7:4]};
				nf = '{z: (r == 8'd0), n: 1'b0, h: 1'b0, c: 1'b0};
			end
			CMD_BIT: begin
				wr = 1'b0;
				nf = '{z: !a[req.bit_index], n: 1'b0, h: 1'b1, c: flags.c};
			end
			default: begin
				// unused code: no operation, flags hold
				wr = 1'b0;
			end
		endcase
	end

	// Pack the result
	assign res = '{
		result_byte:    r,
		result_written: wr,
		zero_out:       nf.z,
		subtract_out:   nf.n,
		half_carry_out: nf.h,
		carry_out:      nf.c
	};

endmodule

`default_nettype wire

// ----- rtl/eight_bit_alu_with_flags.sv -----
// Eight-bit ALU with zero, subtract, half-carry and carry flags. An operation
// is taken into an input register, evaluated by ealu_core against the stored
// flags, and the result lands in an output register: res_valid rises once the
// operation has passed through the input and then the output register, and one
// operation can be taken every cycle unless op stalls. The stored flags update
// as each operation leaves the input register, so rotates through carry, INC,
// DEC and BIT see the flags of the operation just before them. The result
// register lets a new operation enter while a finished result waits; with both
// registers full and res stalled, op stalls.
// Flags reset to zero. Depends on ealu_pkg, ealu_core and the macro header.
`default_nettype none

`include "eight_bit_alu_with_flags_macros.svh"

module eight_bit_alu_with_flags
	import ealu_pkg::*;
(
	input  wire           clk,
	input  wire           arst_n,
	input  wire           op_valid,
	output logic          op_stall,
	input  wire alu_req_t op_data,
	output logic          res_valid,
	input  wire           res_stall,
	output alu_res_t      res_data
);

	alu_req_t   item_s1;
	logic       valid_s1;
	alu_res_t   res_s2;
	logic       valid_s2;
	alu_flags_t flags_q;
	alu_res_t   core_res;
	logic       take_in;
	logic       adv_s1;
	alu_flags_t held_flags;
	logic       keep_carry_adv;
	logic       no_byte_adv;
	logic       byte_clear_s2;

	// Handshake control
	assign adv_s1   = valid_s1 && (!valid_s2 || !res_stall);
	assign op_stall = valid_s1 && !adv_s1;
	assign take_in  = op_valid && !op_stall;

	// Datapath between the two registers
	ealu_core u_core (
		.req   (item_s1),
		.flags (flags_q),
		.res   (core_res)
	);

	// Advance valid bits and flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			flags_q  <= '0;
		end else begin
			valid_s1 <= take_in || (valid_s1 && !adv_s1);
			valid_s2 <= adv_s1 || (valid_s2 && res_stall);
			if (adv_s1) begin
				flags_q <= '{z: core_res.zero_out, n: core_res.subtract_out,
					h: core_res.half_carry_out, c: core_res.carry_out};
			end
		end
	end

	// Load payload registers on transfer
	always_ff @(posedge clk) begin
		if (take_in) begin
			item_s1 <= op_data;
		end
		if (adv_s1) begin
			res_s2 <= core_res;
		end
	end

	assign res_valid = valid_s2;
	assign res_data  = res_s2;

	// Terms for the checks below
	assign held_flags = '{z: res_s2.zero_out, n: res_s2.subtract_out,
		h: res_s2.half_carry_out, c: res_s2.carry_out};
	assign keep_carry_adv = adv_s1 && (item_s1.cmd == CMD_INC || item_s1.cmd == CMD_DEC ||
		item_s1.cmd == CMD_BIT);
	assign no_byte_adv    = adv_s1 && (item_s1.cmd == CMD_CP || item_s1.cmd == CMD_BIT);
	assign byte_clear_s2  = !res_s2.result_written && (res_s2.result_byte == 8'd0);

	// Stored flags always match the result held at the output
	`EALU_ASSERT_NOW(a_flags_track, valid_s2, flags_q == held_flags, "flags differ from held result")
	// INC, DEC and BIT keep the previous carry
	`EALU_ASSERT_NEXT(a_carry_kept, keep_carry_adv, res_s2.carry_out == $past(flags_q.c), "carry changed")
	// Compare and bit test write no byte
	`EALU_ASSERT_NEXT(a_no_write, no_byte_adv, byte_clear_s2, "compare or bit test wrote a byte")

endmodule

`default_nettype wire
